// ===== rtl/adfs_pkg.sv =====
// Shared types, constants and helpers for the adjacency-matrix depth-first search core.
`default_nettype none
package adfs_pkg;

   // Graph sizing
   localparam int MAX_VERTICES = 32;
   localparam int ROW_W        = 32;
   localparam int VTX_W        = 5;
   localparam int COUNT_W      = 6;
   localparam int DEPTH_W      = $clog2(MAX_VERTICES + 1);
   localparam int STK_AW       = $clog2(MAX_VERTICES);

   // Packed widths of the stream beats
   localparam int REQ_BITS  = 2 + VTX_W + VTX_W;
   localparam int REQ_TDATA = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA = ((VTX_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_SEARCH = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   // Request beat, operation in the lowest bits
   typedef struct packed {
      logic [VTX_W-1:0] vertex_b;
      logic [VTX_W-1:0] vertex_a;
      op_type           operation;
   } req_type;

   // Result handed from the sequencer to the output register
   typedef struct packed {
      logic             valid;
      logic [VTX_W-1:0] vertex;
      logic             last;
      logic             error;
   } res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_RD_A,
      ST_EDGE_WR_A,
      ST_EDGE_RD_B,
      ST_EDGE_WR_B,
      ST_ROW_RD,
      ST_SCAN,
      ST_POP,
      ST_FINISH,
      ST_ERROR
   } state_type;

   // One-hot row mask for a vertex
   function automatic logic [ROW_W-1:0] vtx_bit(input logic [VTX_W-1:0] v);
      logic [ROW_W-1:0] m;
      m = '0;
      m[v] = 1'b1;
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/adfs_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module adfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, hold when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/adfs_find_first.sv =====
// Find-first unit: lowest set bit of the open-neighbor row.
`default_nettype none
module adfs_find_first (
   input  wire logic [adfs_pkg::ROW_W-1:0] row,
   output logic                            found,
   output logic      [adfs_pkg::VTX_W-1:0] index
);
   import adfs_pkg::*;

   // Priority encode, lowest index wins
   always_comb begin
      index = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (row[i]) begin
            index = VTX_W'(i);
         end
      end
   end

   assign found = |row;

endmodule
`default_nettype wire

// ===== rtl/adfs_seq.sv =====
// Sequencer: adjacency storage, walk stack and the depth-first walk control.
`default_nettype none
module adfs_seq (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire adfs_pkg::req_type                 req,
   input  wire logic [adfs_pkg::COUNT_W-1:0]      vertex_count,
   input  wire logic                              out_free,
   output adfs_pkg::res_type                      emit
);
   import adfs_pkg::*;

   state_type          state_ff, state_in;
   logic [VTX_W-1:0]   a_ff, a_in;
   logic [VTX_W-1:0]   b_ff, b_in;
   logic [VTX_W-1:0]   top_ff, top_in;
   logic [VTX_W-1:0]   pend_ff, pend_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [ROW_W-1:0]   visited_ff, visited_in;
   logic [ROW_W-1:0]   row_valid_ff, row_valid_in;

   logic               adj_wr_en, adj_rd_en;
   logic [VTX_W-1:0]   adj_wr_addr, adj_rd_addr;
   logic [ROW_W-1:0]   adj_wr_data, adj_rd_data;

   logic               stk_wr_en, stk_rd_en;
   logic [STK_AW-1:0]  stk_wr_addr, stk_rd_addr;
   logic [VTX_W-1:0]   stk_wr_data, stk_rd_data;

   logic [COUNT_W-1:0] live_count;
   logic [ROW_W-1:0]   range_mask;
   logic [ROW_W-1:0]   row_word;
   logic [ROW_W-1:0]   open_row;
   logic               ff_found;
   logic [VTX_W-1:0]   ff_index;
   logic               a_ok, b_ok;
   logic [DEPTH_W-1:0] depth_dec2;

   // Adjacency rows, one word per vertex
   adfs_ram #(.WIDTH(ROW_W), .DEPTH(ROW_W)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   // Walk stack of vertices on the current path
   adfs_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   adfs_find_first u_find_first (
      .row   (open_row),
      .found (ff_found),
      .index (ff_index)
   );

   // Vertex range in effect
   always_comb begin
      live_count = (vertex_count > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                           : vertex_count;
      for (int i = 0; i < ROW_W; i++) begin
         range_mask[i] = (COUNT_W'(i) < live_count);
      end
   end

   assign a_ok       = ({1'b0, req.vertex_a} < live_count);
   assign b_ok       = ({1'b0, req.vertex_b} < live_count);
   assign row_word   = row_valid_ff[top_ff] ? adj_rd_data : '0;
   assign open_row   = row_word & range_mask & ~visited_ff;
   assign depth_dec2 = depth_ff - DEPTH_W'(2);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         visited_ff   <= '0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         visited_ff   <= visited_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      top_ff  <= top_in;
      pend_ff <= pend_in;
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      top_in       = top_ff;
      pend_in      = pend_ff;
      depth_in     = depth_ff;
      visited_in   = visited_ff;
      row_valid_in = row_valid_ff;
      req_ready    = 1'b0;
      emit         = '0;
      adj_wr_en    = 1'b0;
      adj_wr_addr  = a_ff;
      adj_wr_data  = '0;
      adj_rd_en    = 1'b0;
      adj_rd_addr  = top_ff;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = depth_ff[STK_AW-1:0];
      stk_wr_data  = ff_index;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = depth_dec2[STK_AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               a_in = req.vertex_a;
               b_in = req.vertex_b;
               unique case (req.operation)
                  OP_ADD: begin
                     if (a_ok && b_ok) begin
                        state_in = ST_EDGE_RD_A;
                     end
                  end
                  OP_CLEAR: begin
                     row_valid_in = '0;
                  end
                  OP_SEARCH: begin
                     if (!a_ok) begin
                        state_in = ST_ERROR;
                     end else begin
                        visited_in  = vtx_bit(req.vertex_a);
                        top_in      = req.vertex_a;
                        pend_in     = req.vertex_a;
                        depth_in    = DEPTH_W'(1);
                        stk_wr_en   = 1'b1;
                        stk_wr_addr = '0;
                        stk_wr_data = req.vertex_a;
                        state_in    = ST_ROW_RD;
                     end
                  end
                  default: begin
                     // unused code: drop the beat
                  end
               endcase
            end
         end
         ST_EDGE_RD_A: begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = a_ff;
            state_in    = ST_EDGE_WR_A;
         end
         ST_EDGE_WR_A: begin
            adj_wr_en          = 1'b1;
            adj_wr_addr        = a_ff;
            adj_wr_data        = (row_valid_ff[a_ff] ? adj_rd_data : '0) | vtx_bit(b_ff);
            row_valid_in[a_ff] = 1'b1;
            state_in           = ST_EDGE_RD_B;
         end
         ST_EDGE_RD_B: begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = b_ff;
            state_in    = ST_EDGE_WR_B;
         end
         ST_EDGE_WR_B: begin
            adj_wr_en          = 1'b1;
            adj_wr_addr        = b_ff;
            adj_wr_data        = (row_valid_ff[b_ff] ? adj_rd_data : '0) | vtx_bit(a_ff);
            row_valid_in[b_ff] = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_ROW_RD: begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = top_ff;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            priority if (!ff_found) begin
               // dead end: pop the path
               depth_in = depth_ff - DEPTH_W'(1);
               if (depth_ff == DEPTH_W'(1)) begin
                  state_in = ST_FINISH;
               end else begin
                  stk_rd_en = 1'b1;
                  state_in  = ST_POP;
               end
            end else if (depth_ff >= DEPTH_W'(MAX_VERTICES)) begin
               state_in = ST_FINISH;
            end else if (out_free) begin
               // hand off the pending vertex, push the new one
               emit.valid           = 1'b1;
               emit.vertex          = pend_ff;
               pend_in              = ff_index;
               visited_in[ff_index] = 1'b1;
               stk_wr_en            = 1'b1;
               depth_in             = depth_ff + DEPTH_W'(1);
               top_in               = ff_index;
               state_in             = ST_ROW_RD;
            end else begin
               // hold until the output register frees up
            end
         end
         ST_POP: begin
            top_in   = stk_rd_data;
            state_in = ST_ROW_RD;
         end
         ST_FINISH: begin
            if (out_free) begin
               emit.valid  = 1'b1;
               emit.vertex = pend_ff;
               emit.last   = 1'b1;
               depth_in    = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.last  = 1'b1;
               emit.error = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // Path never grows past the stack
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_VERTICES))
      else $error("walk stack depth overflow");

   // A pushed vertex was not visited before
   a_fresh_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && ff_found) |-> !visited_ff[ff_index])
      else $error("find-first picked a visited vertex");

   // Results only go out into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("result emitted into a full output register");

   // The vertex being expanded is always marked visited
   a_top_visited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW_RD) |-> visited_ff[top_ff])
      else $error("expanding an unvisited vertex");

   // A finished search leaves the stack empty
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> depth_ff == '0)
      else $error("stack not emptied at end of search");
`endif

endmodule
`default_nettype wire

// ===== rtl/adjacency_matrix_dfs_order_core.sv =====
// Top level: stream ports, vertex-count register and output register around the sequencer.
// Usage:
//   req_* is the command stream. Each beat adds an undirected edge, clears the
//   graph, or runs a depth-first search from vertex_a. Adds and clears give no
//   result; a search gives one rsp_* beat per visited vertex in visit order,
//   with rsp_tlast on the final one. A start vertex at or above the vertex
//   count gives a single beat with rsp_tuser (error) set and rsp_tlast set.
//   csr_* writes the vertex count; write it only while the core is idle.
// Flow:
//   An add reads and writes the row of vertex_a, then that of vertex_b. A search
//   reads the row of the top vertex, then scans it; it pushes the lowest open
//   neighbor or, at a dead end, pops the path. Each beat passes through the
//   output register before it reaches rsp_*.
//   The core takes no new command while a search or edge update is running.
// Reset:
//   Synchronous reset empties the graph, sets the vertex count to 32 and
//   drops any pending result.
// Stall:
//   When rsp_tready is low the output register holds its beat and the walk
//   waits; no result is lost or repeated.
`default_nettype none
module adjacency_matrix_dfs_order_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: [1:0] operation, [6:2] vertex_a, [11:7] vertex_b, rest zero
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [adfs_pkg::REQ_TDATA-1:0]    req_tdata,
   // result: [4:0] vertex, rest zero
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [adfs_pkg::RSP_TDATA-1:0]    rsp_tdata,
   output logic                                   rsp_tlast,
   // result user: [0] error
   output logic                                   rsp_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [adfs_pkg::COUNT_W-1:0]      csr_data
);
   import adfs_pkg::*;

   logic [COUNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]   rsp_vertex_ff, rsp_vertex_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_error_ff, rsp_error_in;
   logic               out_free;
   req_type            req;
   res_type            emit;

   assign req      = req_type'(req_tdata[REQ_BITS-1:0]);
   assign out_free = !rsp_valid_ff || rsp_tready;

   adfs_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req          (req),
      .vertex_count (vertex_count_ff),
      .out_free     (out_free),
      .emit         (emit)
   );

   // Vertex-count register, always ready
   assign csr_ready       = 1'b1;
   assign vertex_count_in = csr_valid ? csr_data : vertex_count_ff;

   // Output register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_error_in  = rsp_error_ff;
      if (emit.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = emit.vertex;
         rsp_last_in   = emit.last;
         rsp_error_in  = emit.error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= COUNT_W'(32);
         rsp_valid_ff    <= 1'b0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA'(rsp_vertex_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_error_ff;

endmodule
`default_nettype wire
